@@ hdl/pwvm_pkg.sv @@
// Shared types, constants and pitch multiplier table for the wavetable voice mixer.
`default_nettype none
package pwvm_pkg;

  localparam int VOICE_COUNT_DEF = 15;
  localparam int WAVE_DEPTH_DEF  = 1024;

  localparam int KIND_W   = 3;
  localparam int CHAN_W   = 4;
  localparam int KEY_W    = 7;
  localparam int VEL_W    = 7;
  localparam int WHEEL_W  = 14;
  localparam int WIDX_W   = 10;
  localparam int WAVE_W   = 16;
  localparam int INC_W    = 26;
  localparam int PHASE_W  = 32;
  localparam int SAMPLE_W = 12;
  localparam int SUM_W    = 26;
  localparam int MULT_W   = 17;
  localparam int PROD_W   = INC_W + MULT_W;
  localparam int KEY_COUNT = 128;

  typedef enum logic [KIND_W-1:0] {
    KIND_NOTE_ON  = 3'd0,
    KIND_NOTE_OFF = 3'd1,
    KIND_WHEEL    = 3'd2,
    KIND_TICK     = 3'd3,
    KIND_WAVE_WR  = 3'd4,
    KIND_STEP_WR  = 3'd5,
    KIND_SILENCE  = 3'd6
  } kind_e;

  typedef struct packed {
    logic [KEY_W-1:0]   key;
    logic [CHAN_W-1:0]  chan;
    logic [VEL_W-1:0]   vol;
    logic [INC_W-1:0]   inc;
    logic [PHASE_W-1:0] phase;
  } voice_t;

  localparam int PITCH_MICRO [64] = '{
    943874, 945580, 947288, 948999, 950714, 952432, 954152, 955876,
    957603, 959333, 961067, 962803, 964542, 966285, 968031, 969780,
    971532, 973287, 975046, 976807, 978572, 980340, 982111, 983886,
    985663, 987444, 989228, 991015, 992806, 994599, 996396, 998197,
    1000000, 1001807, 1003617, 1005430, 1007246, 1009066, 1010889, 1012716,
    1014545, 1016378, 1018215, 1020054, 1021897, 1023743, 1025593, 1027446,
    1029302, 1031162, 1033025, 1034891, 1036761, 1038634, 1040511, 1042390,
    1044274, 1046160, 1048051, 1049944, 1051841, 1053741, 1055645, 1057552
  };

  typedef logic [MULT_W-1:0] mult_tab_t [64];

  function automatic mult_tab_t mult_table();
    mult_tab_t t;
    longint    a;
    for (int i = 0; i < 64; i++) begin
      a    = longint'(PITCH_MICRO[i]);
      t[i] = MULT_W'((a * 65536 + 500000) / 1000000);
    end
    return t;
  endfunction

  localparam mult_tab_t MULT_Q16 = mult_table();

endpackage
`default_nettype wire

@@ hdl/polyphonic_wavetable_voice_mixer.sv @@
// Top level: event sequencer over the voice memory, pitch bend and sample mix.
//
// One input channel carries events (note on/off, pitch wheel, sample tick,
// wave write, step write, silence) with valid/stall; one output channel
// carries a 12-bit sample, one beat per sample tick only.
// The sequencer handles one event at a time and raises in_stall_o until done.
// Wave write, step write, silence and the unused kind complete in the
// accepting cycle; note on passes through ST_ON_WR and is dropped when no
// voice is free; velocity zero runs as a note off.
// After the accepting cycle a note off scans voices in order: ST_RD per
// inactive voice, ST_RD and ST_VX per active non-matching voice, and ST_RD,
// ST_VX, ST_OFF_WR for the matching voice, which ends the scan. Pitch wheel:
// ST_RD per inactive voice, ST_RD and ST_VX per active voice on another
// channel, ST_RD, ST_VX, ST_BMUL and ST_BWR per matching voice. Sample tick:
// ST_RD per inactive voice, ST_RD, ST_VX and ST_TACC per active voice, then
// ST_FIN loads the sample. The scan is paced by the single read port of the
// voice memory and the read, modify, write of each voice record.
// The result sits in an output register; if it is still stalled when the
// next tick finishes, the sequencer holds until the receiver takes it.
// Reset clears all voices to inactive; wave and step tables are undefined
// until written and must be written before they are read.
`default_nettype none
module polyphonic_wavetable_voice_mixer #(
  parameter int VOICE_COUNT = pwvm_pkg::VOICE_COUNT_DEF,
  parameter int WAVE_DEPTH  = pwvm_pkg::WAVE_DEPTH_DEF
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           in_valid_i,
  output      logic                           in_stall_o,
  input  wire logic [pwvm_pkg::KIND_W-1:0]    kind_i,
  input  wire logic [pwvm_pkg::CHAN_W-1:0]    channel_i,
  input  wire logic [pwvm_pkg::KEY_W-1:0]     key_i,
  input  wire logic [pwvm_pkg::VEL_W-1:0]     velocity_i,
  input  wire logic [pwvm_pkg::WHEEL_W-1:0]   wheel_i,
  input  wire logic [pwvm_pkg::WIDX_W-1:0]    wave_index_i,
  input  wire logic signed [pwvm_pkg::WAVE_W-1:0] wave_value_i,
  input  wire logic [pwvm_pkg::INC_W-1:0]     step_value_i,
  output      logic                           out_valid_o,
  input  wire logic                           out_stall_i,
  output      logic [pwvm_pkg::SAMPLE_W-1:0]  sample_o
);
  import pwvm_pkg::*;

  localparam int VW = (VOICE_COUNT > 1) ? $clog2(VOICE_COUNT) : 1;
  localparam int AW = $clog2(WAVE_DEPTH);
  localparam logic [PHASE_W-1:0] LIMIT = PHASE_W'(WAVE_DEPTH) << 16;

  typedef enum logic [3:0] {
    ST_IDLE, ST_ON_WR, ST_RD, ST_VX, ST_OFF_WR, ST_BMUL, ST_BWR, ST_TACC, ST_FIN
  } state_e;

  typedef enum logic [1:0] {OP_OFF, OP_BEND, OP_TICK} op_e;

  state_e                    state_q;
  op_e                       op_q;
  logic [VW-1:0]             v_q;
  logic [VOICE_COUNT-1:0]    active_q;
  logic [CHAN_W-1:0]         chan_q;
  logic [KEY_W-1:0]          key_q;
  logic [VEL_W-1:0]          vel_q;
  logic [5:0]                msel_q;
  logic [PROD_W-1:0]         prod_q;
  logic                      wave_ok_q;
  logic signed [SUM_W-1:0]   sum_q;
  logic                      out_valid_q;
  logic [SAMPLE_W-1:0]       sample_q;

  voice_t                    vrec;
  voice_t                    vwdata;
  logic                      vwe;
  logic [WAVE_W-1:0]         wave_rd;
  logic [INC_W-1:0]          inc_rd;
  logic [KEY_W-1:0]          inc_raddr;
  logic [AW-1:0]             wave_raddr;
  logic                      accept;
  logic                      wave_we;
  logic                      inc_we;
  logic [VW-1:0]             free_idx;
  logic                      free_any;
  logic [PHASE_W-1:0]        ph_sum;
  logic [PHASE_W-1:0]        ph_new;
  logic                      ph_ok;
  logic signed [WAVE_W-1:0]  wave_sel;
  logic signed [WAVE_W+VEL_W:0] mix_prod;
  logic signed [SUM_W-1:0]   sum_sh;
  logic [SAMPLE_W-1:0]       sample_d;
  logic                      last_voice;

  assign in_stall_o  = (state_q != ST_IDLE);
  assign accept      = in_valid_i && !in_stall_o;
  assign out_valid_o = out_valid_q;
  assign sample_o    = sample_q;
  assign last_voice  = (v_q == VW'(VOICE_COUNT - 1));

  always_comb begin
    free_idx = '0;
    free_any = 1'b0;
    for (int i = VOICE_COUNT - 1; i >= 0; i--) begin
      if (!active_q[i]) begin
        free_idx = VW'(i);
        free_any = 1'b1;
      end
    end
  end

  assign ph_sum   = vrec.phase + PHASE_W'(vrec.inc);
  assign ph_new   = (ph_sum >= LIMIT) ? ph_sum - LIMIT : ph_sum;
  assign ph_ok    = ({16'd0, ph_new[PHASE_W-1:16]} < 32'(WAVE_DEPTH));
  assign wave_sel = wave_ok_q ? $signed(wave_rd) : '0;
  assign mix_prod = wave_sel * $signed({1'b0, vrec.vol});
  assign sum_sh   = sum_q >>> 10;

  always_comb begin
    if (sum_sh > SUM_W'(2047)) begin
      sample_d = '1;
    end else if (sum_sh < -SUM_W'(2048)) begin
      sample_d = '0;
    end else begin
      sample_d = {~sum_sh[SAMPLE_W-1], sum_sh[SAMPLE_W-2:0]};
    end
  end

  always_comb begin
    inc_raddr  = (state_q == ST_IDLE) ? key_i : vrec.key;
    wave_raddr = ph_new[16 +: AW];
    wave_we    = accept && (kind_i == KIND_WAVE_WR) &&
                 (32'(wave_index_i) < 32'(WAVE_DEPTH));
    inc_we     = accept && (kind_i == KIND_STEP_WR);
    vwe        = 1'b0;
    vwdata     = vrec;
    unique case (state_q)
      ST_ON_WR: begin
        vwe          = 1'b1;
        vwdata.key   = key_q;
        vwdata.chan  = chan_q;
        vwdata.vol   = vel_q;
        vwdata.inc   = inc_rd;
        vwdata.phase = '0;
      end
      ST_OFF_WR: begin
        vwe         = 1'b1;
        vwdata.chan = '0;
        vwdata.inc  = inc_rd;
      end
      ST_BWR: begin
        vwe        = 1'b1;
        vwdata.inc = prod_q[PROD_W-1] ? '1 : prod_q[PROD_W-2:16];
      end
      ST_VX: begin
        vwe          = (op_q == OP_TICK);
        vwdata.phase = ph_new;
      end
      default: begin
        vwe = 1'b0;
      end
    endcase
  end

  pwvm_voice_ram #(.VOICE_COUNT(VOICE_COUNT)) u_voice_ram (
    .clk_i   (clk_i),
    .we_i    (vwe),
    .waddr_i (v_q),
    .wdata_i (vwdata),
    .raddr_i (v_q),
    .rdata_o (vrec)
  );

  pwvm_tables #(.WAVE_DEPTH(WAVE_DEPTH)) u_tables (
    .clk_i        (clk_i),
    .wave_we_i    (wave_we),
    .wave_waddr_i (AW'(wave_index_i)),
    .wave_wdata_i (wave_value_i),
    .wave_raddr_i (wave_raddr),
    .wave_rdata_o (wave_rd),
    .inc_we_i     (inc_we),
    .inc_waddr_i  (key_i),
    .inc_wdata_i  (step_value_i),
    .inc_raddr_i  (inc_raddr),
    .inc_rdata_o  (inc_rd)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      op_q        <= OP_OFF;
      v_q         <= '0;
      active_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (out_valid_q && !out_stall_i && state_q != ST_FIN) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (accept) begin
            chan_q <= channel_i;
            key_q  <= key_i;
            vel_q  <= velocity_i;
            msel_q <= wheel_i[WHEEL_W-1 -: 6];
            sum_q  <= '0;
            v_q    <= '0;
            unique case (kind_i)
              KIND_NOTE_ON: begin
                if (velocity_i == '0) begin
                  op_q    <= OP_OFF;
                  state_q <= ST_RD;
                end else if (free_any) begin
                  v_q     <= free_idx;
                  state_q <= ST_ON_WR;
                end
              end
              KIND_NOTE_OFF: begin
                op_q    <= OP_OFF;
                state_q <= ST_RD;
              end
              KIND_WHEEL: begin
                op_q    <= OP_BEND;
                state_q <= ST_RD;
              end
              KIND_TICK: begin
                op_q    <= OP_TICK;
                state_q <= ST_RD;
              end
              KIND_SILENCE: begin
                active_q <= '0;
              end
              default: begin
                state_q <= ST_IDLE;
              end
            endcase
          end
        end
        ST_ON_WR: begin
          active_q[v_q] <= 1'b1;
          state_q       <= ST_IDLE;
        end
        ST_RD: begin
          if (active_q[v_q]) begin
            state_q <= ST_VX;
          end else if (last_voice) begin
            state_q <= (op_q == OP_TICK) ? ST_FIN : ST_IDLE;
          end else begin
            v_q <= v_q + 1'b1;
          end
        end
        ST_VX: begin
          wave_ok_q <= ph_ok;
          if (op_q == OP_TICK) begin
            state_q <= ST_TACC;
          end else if (op_q == OP_OFF && vrec.key == key_q) begin
            state_q <= ST_OFF_WR;
          end else if (op_q == OP_BEND && vrec.chan == chan_q) begin
            state_q <= ST_BMUL;
          end else if (last_voice) begin
            state_q <= ST_IDLE;
          end else begin
            v_q     <= v_q + 1'b1;
            state_q <= ST_RD;
          end
        end
        ST_OFF_WR: begin
          active_q[v_q] <= 1'b0;
          state_q       <= ST_IDLE;
        end
        ST_BMUL: begin
          prod_q  <= PROD_W'(inc_rd) * PROD_W'(MULT_Q16[msel_q]);
          state_q <= ST_BWR;
        end
        ST_BWR, ST_TACC: begin
          if (state_q == ST_TACC) begin
            sum_q <= sum_q + SUM_W'(mix_prod >>> 4);
          end
          if (last_voice) begin
            state_q <= (state_q == ST_TACC) ? ST_FIN : ST_IDLE;
          end else begin
            v_q     <= v_q + 1'b1;
            state_q <= ST_RD;
          end
        end
        ST_FIN: begin
          if (!(out_valid_q && out_stall_i)) begin
            sample_q    <= sample_d;
            out_valid_q <= 1'b1;
            state_q     <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  a_new_voice_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_ON_WR |-> !active_q[v_q])
    else $error("note on overwrites an active voice");

  a_off_frees: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_OFF_WR |=> state_q == ST_IDLE && !active_q[$past(v_q)])
    else $error("note off did not free the voice");

  a_out_from_fin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(state_q == ST_FIN))
    else $error("sample beat raised outside of tick completion");

  a_fin_no_drop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_FIN && out_valid_q && out_stall_i |=> state_q == ST_FIN)
    else $error("tick result overran a stalled sample");

endmodule
`default_nettype wire

@@ hdl/pwvm_voice_ram.sv @@
// Voice record memory: one write port, one registered read port.
`default_nettype none
module pwvm_voice_ram #(
  parameter int VOICE_COUNT = pwvm_pkg::VOICE_COUNT_DEF,
  localparam int VW = (VOICE_COUNT > 1) ? $clog2(VOICE_COUNT) : 1
) (
  input  wire logic            clk_i,
  input  wire logic            we_i,
  input  wire logic [VW-1:0]   waddr_i,
  input  wire pwvm_pkg::voice_t wdata_i,
  input  wire logic [VW-1:0]   raddr_i,
  output pwvm_pkg::voice_t     rdata_o
);
  import pwvm_pkg::*;

  voice_t mem [VOICE_COUNT];
  voice_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;
endmodule
`default_nettype wire

@@ hdl/pwvm_tables.sv @@
// Wave sample memory and per-key step memory, each with a registered read port.
`default_nettype none
module pwvm_tables #(
  parameter int WAVE_DEPTH = pwvm_pkg::WAVE_DEPTH_DEF,
  localparam int AW = $clog2(WAVE_DEPTH)
) (
  input  wire logic                         clk_i,
  input  wire logic                         wave_we_i,
  input  wire logic [AW-1:0]                wave_waddr_i,
  input  wire logic [pwvm_pkg::WAVE_W-1:0]  wave_wdata_i,
  input  wire logic [AW-1:0]                wave_raddr_i,
  output      logic [pwvm_pkg::WAVE_W-1:0]  wave_rdata_o,
  input  wire logic                         inc_we_i,
  input  wire logic [pwvm_pkg::KEY_W-1:0]   inc_waddr_i,
  input  wire logic [pwvm_pkg::INC_W-1:0]   inc_wdata_i,
  input  wire logic [pwvm_pkg::KEY_W-1:0]   inc_raddr_i,
  output      logic [pwvm_pkg::INC_W-1:0]   inc_rdata_o
);
  import pwvm_pkg::*;

  logic [WAVE_W-1:0] wave_mem [WAVE_DEPTH];
  logic [INC_W-1:0]  inc_mem  [KEY_COUNT];

  always_ff @(posedge clk_i) begin
    if (wave_we_i) begin
      wave_mem[wave_waddr_i] <= wave_wdata_i;
    end
    wave_rdata_o <= wave_mem[wave_raddr_i];
  end

  always_ff @(posedge clk_i) begin
    if (inc_we_i) begin
      inc_mem[inc_waddr_i] <= inc_wdata_i;
    end
    inc_rdata_o <= inc_mem[inc_raddr_i];
  end
endmodule
`default_nettype wire

@@ dv/polyphonic_wavetable_voice_mixer_tb.sv @@
// Self-checking testbench for the wavetable voice mixer: random and directed events, sample check.
module polyphonic_wavetable_voice_mixer_tb;
  import pwvm_pkg::*;

  localparam int VOICES      = VOICE_COUNT_DEF;
  localparam int DEPTH       = WAVE_DEPTH_DEF;
  localparam int STALL_LIMIT = 3000;
  localparam int RANDOM_ITEMS = 460;
  localparam logic [INC_W-1:0] STEP_MAX = {INC_W{1'b1}};
  localparam logic [KIND_W-1:0] KIND_UNUSED = 3'd7;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic out_stall = 1'b0;
  logic [KIND_W-1:0] kind = '0;
  logic [CHAN_W-1:0] chan = '0;
  logic [KEY_W-1:0] key = '0;
  logic [VEL_W-1:0] vel = '0;
  logic [WHEEL_W-1:0] wheel = '0;
  logic [WIDX_W-1:0] widx = '0;
  logic signed [WAVE_W-1:0] wval = '0;
  logic [INC_W-1:0] step = '0;
  wire in_stall;
  wire out_valid;
  wire [SAMPLE_W-1:0] sample;

  bit quiet = 1'b0;
  int mismatches = 0;
  int idle_cycles = 0;

  logic [SAMPLE_W-1:0] sample_q[$];

  logic               v_active [VOICES];
  logic [KEY_W-1:0]   v_key    [VOICES];
  logic [CHAN_W-1:0]  v_chan   [VOICES];
  logic [VEL_W-1:0]   v_vol    [VOICES];
  logic [INC_W-1:0]   v_inc    [VOICES];
  logic [PHASE_W-1:0] v_phase  [VOICES];
  logic signed [WAVE_W-1:0] wave_mem [DEPTH];
  logic [INC_W-1:0] step_mem [KEY_COUNT];

  always #2 clk = ~clk;

  polyphonic_wavetable_voice_mixer uut (
    .clk_i(clk), .rst_ni(rst_n),
    .in_valid_i(in_valid), .in_stall_o(in_stall),
    .kind_i(kind), .channel_i(chan), .key_i(key), .velocity_i(vel),
    .wheel_i(wheel), .wave_index_i(widx), .wave_value_i(wval), .step_value_i(step),
    .out_valid_o(out_valid), .out_stall_i(out_stall), .sample_o(sample)
  );

  function automatic longint pitch_q16(int sel);
    return (longint'(PITCH_MICRO[sel]) * 65536 + 500000) / 1000000;
  endfunction

  function automatic void clear_voices();
    for (int v = 0; v < VOICES; v++) begin
      v_active[v] = 1'b0; v_key[v] = '0; v_chan[v] = '0;
      v_vol[v] = '0; v_inc[v] = '0; v_phase[v] = '0;
    end
  endfunction

  function automatic void release_note(logic [KEY_W-1:0] k);
    for (int v = 0; v < VOICES; v++) begin
      if (v_active[v] && v_key[v] == k) begin
        v_active[v] = 1'b0;
        v_chan[v] = '0;
        v_inc[v] = step_mem[k];
        return;
      end
    end
  endfunction

  function automatic void predict_event(logic [KIND_W-1:0] kd, logic [CHAN_W-1:0] ch,
      logic [KEY_W-1:0] k, logic [VEL_W-1:0] vl, logic [WHEEL_W-1:0] wh,
      logic [WIDX_W-1:0] wi, logic signed [WAVE_W-1:0] wv, logic [INC_W-1:0] sv);
    longint mult;
    longint prod;
    int sum;
    int acc;
    logic [PHASE_W-1:0] lim;
    lim = PHASE_W'(DEPTH) << 16;
    case (kd)
      KIND_NOTE_ON: begin
        if (vl == 0) begin
          release_note(k);
        end else begin
          for (int v = 0; v < VOICES; v++) begin
            if (!v_active[v]) begin
              v_key[v] = k; v_inc[v] = step_mem[k]; v_phase[v] = '0;
              v_vol[v] = vl; v_chan[v] = ch; v_active[v] = 1'b1;
              break;
            end
          end
        end
      end
      KIND_NOTE_OFF: release_note(k);
      KIND_WHEEL: begin
        mult = pitch_q16(int'(wh[13:8]));
        for (int v = 0; v < VOICES; v++) begin
          if (v_active[v] && v_chan[v] == ch) begin
            prod = (longint'(step_mem[v_key[v]]) * mult) >>> 16;
            v_inc[v] = (prod > longint'(STEP_MAX)) ? STEP_MAX : INC_W'(prod);
          end
        end
      end
      KIND_TICK: begin
        sum = 0;
        for (int v = 0; v < VOICES; v++) begin
          if (v_active[v]) begin
            v_phase[v] = v_phase[v] + PHASE_W'(v_inc[v]);
            if (v_phase[v] >= lim) v_phase[v] = v_phase[v] - lim;
            acc = (v_phase[v] >> 16) < DEPTH ? int'(wave_mem[v_phase[v] >> 16]) : 0;
            sum += (acc * int'(v_vol[v])) >>> 4;
          end
        end
        sum = (sum >>> 10) + 2048;
        if (sum > 4095) sum = 4095;
        else if (sum < 0) sum = 0;
        sample_q.push_back(SAMPLE_W'(sum));
      end
      KIND_WAVE_WR: if (wi < DEPTH) wave_mem[wi] = wv;
      KIND_STEP_WR: step_mem[k] = sv;
      KIND_SILENCE: clear_voices();
      default: ;
    endcase
  endfunction

  task automatic send_item(logic [KIND_W-1:0] kd, logic [CHAN_W-1:0] ch,
      logic [KEY_W-1:0] k, logic [VEL_W-1:0] vl, logic [WHEEL_W-1:0] wh,
      logic [WIDX_W-1:0] wi, logic signed [WAVE_W-1:0] wv, logic [INC_W-1:0] sv);
    in_valid <= 1'b1;
    kind <= kd; chan <= ch; key <= k; vel <= vl;
    wheel <= wh; widx <= wi; wval <= wv; step <= sv;
    do @(posedge clk); while (in_stall);
    predict_event(kd, ch, k, vl, wh, wi, wv, sv);
    @(negedge clk);
    if (!quiet && $urandom_range(0, 7) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk);
    end
  endtask

  task automatic send_kind(logic [KIND_W-1:0] kd, logic [CHAN_W-1:0] ch,
      logic [KEY_W-1:0] k, logic [VEL_W-1:0] vl, logic [WHEEL_W-1:0] wh);
    send_item(kd, ch, k, vl, wh, WIDX_W'($urandom), WAVE_W'($urandom), INC_W'($urandom));
  endtask

  task automatic drain_outputs();
    in_valid <= 1'b0;
    while (sample_q.size() != 0) @(negedge clk);
  endtask

  task automatic test_table_fill();
    for (int i = 0; i < DEPTH; i++)
      send_item(KIND_WAVE_WR, CHAN_W'($urandom), KEY_W'($urandom), VEL_W'($urandom),
                WHEEL_W'($urandom), WIDX_W'(i), WAVE_W'($urandom), INC_W'($urandom));
    for (int i = 0; i < KEY_COUNT; i++)
      send_item(KIND_STEP_WR, CHAN_W'($urandom), KEY_W'(i), VEL_W'($urandom),
                WHEEL_W'($urandom), WIDX_W'($urandom), WAVE_W'($urandom),
                INC_W'($urandom_range(0, 32'h0004_0000)));
  endtask

  task automatic test_directed();
    send_item(KIND_WAVE_WR, 0, 0, 0, 0, '1, 16'sh7FFF, 0);
    send_item(KIND_WAVE_WR, 0, 0, 0, 0, 0, -16'sd32768, 0);
    send_item(KIND_STEP_WR, 0, 127, 0, 0, 0, 0, STEP_MAX);
    send_item(KIND_STEP_WR, 0, 0, 0, 0, 0, 0, '0);
    send_kind(KIND_TICK, 0, 0, 0, 0);
    send_kind(KIND_NOTE_ON, 15, 127, 127, 0);
    send_kind(KIND_NOTE_ON, 15, 0, 127, 0);
    send_kind(KIND_WHEEL, 15, 0, 0, '1);
    send_kind(KIND_TICK, 0, 0, 0, 0);
    send_kind(KIND_WHEEL, 15, 0, 0, '0);
    send_kind(KIND_TICK, 0, 0, 0, 0);
    send_kind(KIND_NOTE_OFF, 3, 127, 0, 0);
    send_kind(KIND_NOTE_OFF, 3, 127, 0, 0);
    send_kind(KIND_TICK, 0, 0, 0, 0);
    for (int i = 0; i < VOICES + 1; i++) send_kind(KIND_NOTE_ON, 4'(i), 7'(i + 1), 127, 0);
    send_kind(KIND_TICK, 0, 0, 0, 0);
    send_kind(KIND_NOTE_ON, 1, 2, 0, 0);
    send_kind(KIND_UNUSED, 0, 0, 0, 0);
    send_kind(KIND_TICK, 0, 0, 0, 0);
    send_kind(KIND_SILENCE, 0, 0, 0, 0);
    send_kind(KIND_TICK, 0, 0, 0, 0);
  endtask

  task automatic test_random(int count);
    int n;
    int r;
    n = 0;
    while (n < count) begin
      r = $urandom_range(0, 99);
      n++;
      if (r < 30) send_kind(KIND_TICK, CHAN_W'($urandom), KEY_W'($urandom),
                            VEL_W'($urandom), WHEEL_W'($urandom));
      else if (r < 55) send_kind(KIND_NOTE_ON, CHAN_W'($urandom_range(0, 3)),
                                 KEY_W'($urandom_range(0, 15)),
                                 ($urandom_range(0, 9) == 0) ? '0 : VEL_W'($urandom),
                                 WHEEL_W'($urandom));
      else if (r < 70) send_kind(KIND_NOTE_OFF, CHAN_W'($urandom),
                                 KEY_W'($urandom_range(0, 15)), VEL_W'($urandom),
                                 WHEEL_W'($urandom));
      else if (r < 80) send_kind(KIND_WHEEL, CHAN_W'($urandom_range(0, 3)),
                                 KEY_W'($urandom), VEL_W'($urandom), WHEEL_W'($urandom));
      else if (r < 86) send_item(KIND_STEP_WR, CHAN_W'($urandom), KEY_W'($urandom),
                                 VEL_W'($urandom), WHEEL_W'($urandom), WIDX_W'($urandom),
                                 WAVE_W'($urandom), INC_W'($urandom));
      else if (r < 93) send_item(KIND_WAVE_WR, CHAN_W'($urandom), KEY_W'($urandom),
                                 VEL_W'($urandom), WHEEL_W'($urandom), WIDX_W'($urandom),
                                 WAVE_W'($urandom), INC_W'($urandom));
      else if (r < 95) send_kind(KIND_SILENCE, CHAN_W'($urandom), KEY_W'($urandom),
                                 VEL_W'($urandom), WHEEL_W'($urandom));
      else if (r < 96) begin
        n--;
        send_kind(KIND_UNUSED, CHAN_W'($urandom), KEY_W'($urandom), VEL_W'($urandom),
                  WHEEL_W'($urandom));
      end else send_kind(KIND_TICK, 0, 0, 0, 0);
    end
  endtask

  always @(posedge clk) begin
    if (out_valid && !out_stall) begin
      if (sample_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected sample %0d", sample);
      end else begin
        if (sample !== sample_q[0]) begin
          mismatches++;
          if (mismatches <= 10)
            $display("sample mismatch: expected %0d actual %0d", sample_q[0], sample);
        end
        void'(sample_q.pop_front());
      end
    end
  end

  always @(negedge clk) begin
    if (quiet || !rst_n) begin
      out_stall <= 1'b0;
    end else if (out_stall) begin
      if ($urandom_range(0, 2) == 0) out_stall <= 1'b0;
    end else if ($urandom_range(0, 9) == 0) begin
      out_stall <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || !rst_n) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    clear_voices();
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    test_table_fill();
    test_directed();
    test_random(RANDOM_ITEMS / 2);
    drain_outputs();
    repeat ($urandom_range(1, 6)) @(negedge clk);
    test_random(RANDOM_ITEMS * 3 / 10);
    quiet = 1'b1;
    test_random(RANDOM_ITEMS / 5);
    drain_outputs();
    repeat (100) @(negedge clk);
    if (mismatches == 0 && sample_q.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end
endmodule
